>>> rtl/sri_pkg.sv
// Shared types, widths and constants for the Sellmeier refractive index unit.
`timescale 1ns / 1ps
`default_nettype none
package sri_pkg;

   localparam int MAX_TERMS   = 3;
   localparam int WL_W        = 24;
   localparam int COEF_W      = 32;
   localparam int TERMS_W     = 2;
   localparam int CSR_IDX_W   = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CONSTANT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TERMS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_TERM = 3'd2;

   localparam logic [COEF_W-1:0] CONSTANT_RESET = 32'h0100_0000;

   // Status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_POLE     = 2'd1;
   localparam logic [1:0] STATUS_NEGATIVE = 2'd2;

   // w2 = round(wl^2 * 256 / 1e6) = floor((4*wl^2 + 7812) / 15625), Q.24 um^2
   localparam int W2_W        = 37;
   localparam int NUM_W       = 51;
   localparam int W2_DIGIT_W  = 17;
   localparam int W2_STEPS    = 3;
   localparam int W2_REM_W    = 14;
   localparam int W2_TRIAL_W  = W2_REM_W + W2_DIGIT_W;
   localparam int W2_PROD_W   = 63;
   localparam int W2_SHIFT    = 45;
   localparam logic [W2_REM_W-1:0] W2_DIVISOR = 14'd15625;
   localparam logic [31:0]         W2_RECIP   = 32'd2251799814;  // ceil(2^45 / 15625)
   localparam logic [NUM_W-1:0]    W2_ROUND   = 51'd7812;

   // Term division K*w2/|d|
   localparam int D_W       = 39;
   localparam int MD_W      = 38;
   localparam int PROD_W    = 68;
   localparam int QUO_W     = 41;
   localparam int DIV_STEPS = QUO_W;
   localparam int TERM_W    = 42;
   localparam logic [QUO_W-1:0] TERM_LIMIT = 41'h100_0000_0000;
   localparam int LANE_LAT  = DIV_STEPS + 3;

   // n^2 sum and square root
   localparam int SUM_W      = 44;
   localparam int ROOT_W     = 32;
   localparam int SQ_REM_W   = 35;
   localparam int SQRT_STEPS = ROOT_W;

   localparam int PIPE_DEPTH = 1 + W2_STEPS + LANE_LAT + 1 + SQRT_STEPS;

   typedef struct packed {
      logic [W2_REM_W-1:0] rem;
      logic [NUM_W-1:0]    num;
      logic [NUM_W-1:0]    quo;
   } w2_step_type;

   typedef struct packed {
      logic [MD_W-1:0]  rem;
      logic [QUO_W-1:0] num;
      logic [QUO_W-1:0] quo;
      logic [MD_W-1:0]  md;
      logic             neg;
      logic             over;
      logic             pole;
      logic             act;
   } div_step_type;

   typedef struct packed {
      logic [SQ_REM_W-1:0] rem;
      logic [ROOT_W-1:0]   root;
      logic [ROOT_W-1:0]   x;
      logic [1:0]          status;
      logic                cap;
   } sqrt_step_type;

endpackage
`default_nettype wire

>>> rtl/sri_w2_cell.sv
// One base-2^17 digit of the divide by 15625 that forms w2.
`timescale 1ns / 1ps
`default_nettype none
module sri_w2_cell (
   input  wire logic                 clock,
   input  wire logic                 advance,
   input  wire sri_pkg::w2_step_type step_i,
   output sri_pkg::w2_step_type      step_o
);
   import sri_pkg::*;

   w2_step_type             step_ff, step_in;
   logic [W2_TRIAL_W-1:0]   trial;
   logic [W2_PROD_W-1:0]    prod;
   logic [W2_DIGIT_W-1:0]   digit;
   logic [W2_TRIAL_W-1:0]   back;
   logic [W2_TRIAL_W-1:0]   diff;

   always_comb begin
      // trial < 15625 * 2^17, well inside the range where the reciprocal is exact
      trial = {step_i.rem, step_i.num[NUM_W-1 -: W2_DIGIT_W]};
      prod  = {{(W2_PROD_W-W2_TRIAL_W){1'b0}}, trial} *
              {{(W2_PROD_W-32){1'b0}}, W2_RECIP};
      digit = prod[W2_SHIFT +: W2_DIGIT_W];
      back  = {{(W2_TRIAL_W-W2_DIGIT_W){1'b0}}, digit} *
              {{(W2_TRIAL_W-W2_REM_W){1'b0}}, W2_DIVISOR};
      diff  = trial - back;
      step_in.rem = diff[W2_REM_W-1:0];
      step_in.num = {step_i.num[NUM_W-W2_DIGIT_W-1:0], {W2_DIGIT_W{1'b0}}};
      step_in.quo = {step_i.quo[NUM_W-W2_DIGIT_W-1:0], digit};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         step_ff <= step_in;
      end
   end

   assign step_o = step_ff;
endmodule
`default_nettype wire

>>> rtl/sri_div_cell.sv
// One restoring step of the term quotient K*w2/|w2-L|.
`timescale 1ns / 1ps
`default_nettype none
module sri_div_cell (
   input  wire logic                  clock,
   input  wire logic                  advance,
   input  wire sri_pkg::div_step_type step_i,
   output sri_pkg::div_step_type      step_o
);
   import sri_pkg::*;

   div_step_type step_ff, step_in;
   logic [MD_W:0] trial;
   logic [MD_W:0] diff;

   always_comb begin
      step_in = step_i;
      trial   = {step_i.rem, step_i.num[QUO_W-1]};
      diff    = trial - {1'b0, step_i.md};
      step_in.num = {step_i.num[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, step_i.md}) begin
         step_in.rem = diff[MD_W-1:0];
         step_in.quo = {step_i.quo[QUO_W-2:0], 1'b1};
      end else begin
         step_in.rem = trial[MD_W-1:0];
         step_in.quo = {step_i.quo[QUO_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         step_ff <= step_in;
      end
   end

   assign step_o = step_ff;
endmodule
`default_nettype wire

>>> rtl/sri_sqrt_cell.sv
// One result bit of the digit-by-digit integer square root.
`timescale 1ns / 1ps
`default_nettype none
module sri_sqrt_cell (
   input  wire logic                   clock,
   input  wire logic                   advance,
   input  wire sri_pkg::sqrt_step_type step_i,
   output sri_pkg::sqrt_step_type      step_o
);
   import sri_pkg::*;

   sqrt_step_type step_ff, step_in;
   logic [SQ_REM_W-1:0] trial;
   logic [SQ_REM_W-1:0] test;

   always_comb begin
      step_in = step_i;
      trial   = {step_i.rem[SQ_REM_W-3:0], step_i.x[ROOT_W-1:ROOT_W-2]};
      test    = {1'b0, step_i.root, 2'b01};
      step_in.x = {step_i.x[ROOT_W-3:0], 2'b00};
      if (trial >= test) begin
         step_in.rem  = trial - test;
         step_in.root = {step_i.root[ROOT_W-2:0], 1'b1};
      end else begin
         step_in.rem  = trial;
         step_in.root = {step_i.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         step_ff <= step_in;
      end
   end

   assign step_o = step_ff;
endmodule
`default_nettype wire

>>> rtl/sri_term_lane.sv
// One Sellmeier term: K*w2/(w2-L), truncated, saturated and signed.
`timescale 1ns / 1ps
`default_nettype none
module sri_term_lane (
   input  wire logic                         clock,
   input  wire logic                         advance,
   input  wire logic [sri_pkg::W2_W-1:0]     w2,
   input  wire logic [sri_pkg::COEF_W-1:0]   strength,
   input  wire logic [sri_pkg::COEF_W-1:0]   pole,
   input  wire logic                         active,
   output logic signed [sri_pkg::TERM_W-1:0] term_value,
   output logic                              at_pole
);
   import sri_pkg::*;

   // front stage: difference, magnitudes, partial products
   logic [D_W-1:0]    d;
   logic [D_W-1:0]    d_neg;
   logic [COEF_W-1:0] mk;
   logic [MD_W-1:0]   md_in,  md_ff;
   logic [63:0]       pp_lo_in, pp_lo_ff;
   logic [35:0]       pp_hi_in, pp_hi_ff;
   logic              neg_in, neg_ff;
   logic              pole_in, pole_ff;
   logic              act_ff;

   always_comb begin
      d        = {2'b00, w2} - {{(D_W-COEF_W){pole[COEF_W-1]}}, pole};
      d_neg    = '0 - d;
      md_in    = d[D_W-1] ? d_neg[MD_W-1:0] : d[MD_W-1:0];
      mk       = strength[COEF_W-1] ? ('0 - strength) : strength;
      pp_lo_in = {32'b0, mk} * {32'b0, w2[31:0]};
      pp_hi_in = {4'b0, mk} * {31'b0, w2[W2_W-1:32]};
      neg_in   = strength[COEF_W-1] ^ d[D_W-1];
      pole_in  = active && (d == '0);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         md_ff    <= md_in;
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
         neg_ff   <= neg_in;
         pole_ff  <= pole_in;
         act_ff   <= active;
      end
   end

   // product, early overflow test, divider seed
   logic [PROD_W-1:0] prod;
   div_step_type      seed_in, seed_ff;

   always_comb begin
      prod         = {4'b0, pp_lo_ff} + {pp_hi_ff, 32'b0};
      seed_in.over = {11'b0, prod[PROD_W-1:QUO_W]} >= md_ff;
      seed_in.rem  = {11'b0, prod[PROD_W-1:QUO_W]};
      seed_in.num  = prod[QUO_W-1:0];
      seed_in.quo  = '0;
      seed_in.md   = md_ff;
      seed_in.neg  = neg_ff;
      seed_in.pole = pole_ff;
      seed_in.act  = act_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         seed_ff <= seed_in;
      end
   end

   // quotient chain, one bit per cell
   div_step_type chain [DIV_STEPS+1];
   assign chain[0] = seed_ff;

   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
      sri_div_cell u_cell (
         .clock   (clock),
         .advance (advance),
         .step_i  (chain[s]),
         .step_o  (chain[s+1])
      );
   end

   // saturate and sign
   div_step_type              fin;
   logic [QUO_W-1:0]          qsat;
   logic [TERM_W-1:0]         qext;
   logic signed [TERM_W-1:0]  term_in, term_ff;
   logic                      at_pole_in, at_pole_ff;

   always_comb begin
      fin  = chain[DIV_STEPS];
      qsat = (fin.over || (fin.quo > TERM_LIMIT)) ? TERM_LIMIT : fin.quo;
      qext = {1'b0, qsat};
      if (!fin.act || fin.pole) begin
         term_in = '0;
      end else if (fin.neg) begin
         term_in = '0 - qext;
      end else begin
         term_in = qext;
      end
      at_pole_in = fin.act && fin.pole;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         term_ff    <= term_in;
         at_pole_ff <= at_pole_in;
      end
   end

   assign term_value = term_ff;
   assign at_pole    = at_pole_ff;
endmodule
`default_nettype wire

>>> rtl/sellmeier_refractive_index_unit.sv
// Sellmeier refractive index unit: wavelength in, Q4.28 index and status out.
//
//  channel  direction  handshake            word
//  req_     in         req_valid/req_stall  wavelength, nm with 8 fraction bits
//  rsp_     out        rsp_valid/rsp_stall  index_value Q4.28, status
//  csr_     in         csr_valid/csr_ready  csr_index, csr_wdata (always ready)
//
// One word per cycle sustained while the output is not stalled; from accept to rsp_valid
// a word passes 1 square, 3 divide-by-15625 digit cells, 44 term stages (41 quotient
// cells per term lane), 1 sum, 32 square root cells, 1 output register.
// Reset clears the valid chain, output valid and the registers to n^2 = 1.0.
// A stalled output word freezes the whole chain; req_stall follows it.
`timescale 1ns / 1ps
`default_nettype none
module sellmeier_refractive_index_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [sri_pkg::WL_W-1:0]        req_wavelength,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [31:0]                          rsp_index_value,
   output logic [1:0]                           rsp_status,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [sri_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [sri_pkg::COEF_W-1:0]      csr_wdata
);
   import sri_pkg::*;

   // ---------------- configuration registers ----------------
   logic [COEF_W-1:0]  constant_ff;
   logic [TERMS_W-1:0] terms_ff;
   logic [COEF_W-1:0]  strength_ff [MAX_TERMS];
   logic [COEF_W-1:0]  pole_ff     [MAX_TERMS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         constant_ff <= CONSTANT_RESET;
         terms_ff    <= '0;
         for (int t = 0; t < MAX_TERMS; t++) begin
            strength_ff[t] <= '0;
            pole_ff[t]     <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_CONSTANT) begin
            constant_ff <= csr_wdata;
         end
         if (csr_index == CSR_TERMS) begin
            terms_ff <= csr_wdata[TERMS_W-1:0];
         end
         for (int t = 0; t < MAX_TERMS; t++) begin
            if (csr_index == CSR_IDX_W'(CSR_FIRST_TERM + 2 * t)) begin
               strength_ff[t] <= csr_wdata;
            end
            if (csr_index == CSR_IDX_W'(CSR_FIRST_TERM + 2 * t + 1)) begin
               pole_ff[t] <= csr_wdata;
            end
         end
      end
   end

   // ---------------- flow control ----------------
   // Whole chain moves together; the output register takes the last stage.
   logic                  advance;
   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         valid_in     = {valid_ff[PIPE_DEPTH-2:0], req_valid};
         rsp_valid_in = valid_ff[PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- w2: square, then divide by 15625 ----------------
   // floor((wl^2*256 + 500000) / 1e6) == floor((4*wl^2 + 7812) / 15625)
   logic [NUM_W-1:0] num_in, num_ff;
   logic [47:0]      wl_sq;

   always_comb begin
      wl_sq  = {24'b0, req_wavelength} * {24'b0, req_wavelength};
      num_in = {1'b0, wl_sq, 2'b0} + W2_ROUND;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff <= num_in;
      end
   end

   // three 17-bit digits, most significant first
   w2_step_type w2_chain [W2_STEPS+1];
   assign w2_chain[0].rem = '0;
   assign w2_chain[0].num = num_ff;
   assign w2_chain[0].quo = '0;

   for (genvar s = 0; s < W2_STEPS; s++) begin : g_w2
      sri_w2_cell u_cell (
         .clock   (clock),
         .advance (advance),
         .step_i  (w2_chain[s]),
         .step_o  (w2_chain[s+1])
      );
   end

   // ---------------- term lanes ----------------
   logic signed [TERM_W-1:0] lane_term [MAX_TERMS];
   logic [MAX_TERMS-1:0]     lane_pole;

   for (genvar t = 0; t < MAX_TERMS; t++) begin : g_lane
      sri_term_lane u_lane (
         .clock      (clock),
         .advance    (advance),
         .w2         (w2_chain[W2_STEPS].quo[W2_W-1:0]),
         .strength   (strength_ff[t]),
         .pole       (pole_ff[t]),
         .active     (terms_ff > TERMS_W'(t)),
         .term_value (lane_term[t]),
         .at_pole    (lane_pole[t])
      );
   end

   // ---------------- n^2 sum and classification ----------------
   logic [SUM_W-1:0] n2;
   sqrt_step_type    root_seed_in, root_seed_ff;

   always_comb begin
      n2 = {{(SUM_W-COEF_W){constant_ff[COEF_W-1]}}, constant_ff};
      for (int t = 0; t < MAX_TERMS; t++) begin
         n2 = n2 + {{(SUM_W-TERM_W){lane_term[t][TERM_W-1]}}, lane_term[t]};
      end
      root_seed_in.rem  = '0;
      root_seed_in.root = '0;
      root_seed_in.x    = n2[ROOT_W-1:0];
      root_seed_in.cap  = (n2[SUM_W-2:ROOT_W] != '0);
      if (lane_pole != '0) begin
         root_seed_in.status = STATUS_POLE;
      end else if (n2[SUM_W-1]) begin
         root_seed_in.status = STATUS_NEGATIVE;
      end else begin
         root_seed_in.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         root_seed_ff <= root_seed_in;
      end
   end

   // ---------------- square root of n^2 * 2^32 ----------------
   sqrt_step_type root_chain [SQRT_STEPS+1];
   assign root_chain[0] = root_seed_ff;

   for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
      sri_sqrt_cell u_cell (
         .clock   (clock),
         .advance (advance),
         .step_i  (root_chain[s]),
         .step_o  (root_chain[s+1])
      );
   end

   // ---------------- output register ----------------
   sqrt_step_type root_last;
   logic [31:0]   index_in, index_ff;
   logic [1:0]    status_in, status_ff;

   always_comb begin
      root_last = root_chain[SQRT_STEPS];
      status_in = root_last.status;
      if (root_last.status != STATUS_OK) begin
         index_in = '0;
      end else if (root_last.cap) begin
         index_in = '1;
      end else begin
         index_in = root_last.root;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         index_ff  <= index_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_index_value = index_ff;
   assign rsp_status      = status_ff;

   // ---------------- checks ----------------
   a_fault_zero_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_index_value == '0)
      else $error("index not zero on fault status");

   a_chain_frozen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(valid_ff))
      else $error("pipeline moved under output stall");

   a_last_stage_out: assert property (@(posedge clock) disable iff (reset)
      valid_ff[PIPE_DEPTH-1] && advance |=> rsp_valid)
      else $error("word lost at output register");

endmodule
`default_nettype wire
